[hdl/vipt_pkg.sv]
// Shared widths, request and status codes, and controller/datapath handshake types.
package vipt_pkg;

    localparam int REQ_W     = 2;
    localparam int ID_W      = 32;
    localparam int PROF_W    = 2;
    localparam int IDENT_W   = 64;
    localparam int LEN_W     = 8;
    localparam int GEN_W     = 64;
    localparam int STATUS_W  = 3;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int IDENTITY_BYTES  = 8;

    localparam logic [REQ_W-1:0] REQ_SET    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;

    localparam logic [PROF_W-1:0] PROF_PUBLIC  = 2'd0;
    localparam logic [PROF_W-1:0] PROF_TRUSTED = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MALFORMED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

    localparam logic [GEN_W-1:0] GEN_RESET = 64'd1;
    localparam logic [GEN_W-1:0] GEN_MAX   = {GEN_W{1'b1}};

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;      // latch a new request
        logic pre_done;    // finish with the precheck result
        logic scan_start;  // read entry 0
        logic scan_next;   // read the next entry and advance
        logic hit;         // finish a lookup or set on the matching entry
        logic miss;        // finish when no entry matches (empty table or scan found nothing)
        logic shift_rd;    // read the entry above the current slot
        logic shift_wr;    // move the read entry down one slot
        logic clear;       // drop the last slot and bump the generation
        logic load_out;    // move the result into the output register
    } vipt_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic pre_fail;
        logic is_remove;
        logic used_zero;
        logic match;
        logic more;
        logic out_free;
    } vipt_sts_t;

endpackage

[hdl/vipt_req_if.sv]
// Request channel: valid/ready handshake with the table request payload.
interface vipt_req_if;
    import vipt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [REQ_W-1:0]     req_type;
    logic [ID_W-1:0]      iface_id;
    logic [PROF_W-1:0]    profile_code;
    logic [IDENT_W-1:0]   identity_word;
    logic [LEN_W-1:0]     identity_len;
    logic [GEN_W-1:0]     expected_gen;

    modport source (
        output valid, req_type, iface_id, profile_code, identity_word, identity_len,
               expected_gen,
        input  ready
    );

    modport sink (
        input  valid, req_type, iface_id, profile_code, identity_word, identity_len,
               expected_gen,
        output ready
    );
endinterface

[hdl/vipt_rsp_if.sv]
// Response channel: valid/ready handshake with status, new generation and profile.
interface vipt_rsp_if;
    import vipt_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [GEN_W-1:0]      new_gen;
    logic [PROF_W-1:0]     lookup_profile;

    modport source (
        output valid, status, new_gen, lookup_profile,
        input  ready
    );

    modport sink (
        input  valid, status, new_gen, lookup_profile,
        output ready
    );
endinterface

[hdl/vipt_ctrl.sv]
// Controller state machine: sequences precheck, entry scan, shift-down and result hand-off.
module vipt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  vipt_pkg::vipt_sts_t sts,
    output vipt_pkg::vipt_cmd_t cmd
);
    import vipt_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_CHECK    = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_SHIFT_RD = 3'd3;
    localparam logic [2:0] S_SHIFT_WR = 3'd4;
    localparam logic [2:0] S_FINISH   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.pre_fail)
                begin
                    cmd.pre_done = 1'b1;
                    state_next   = S_FINISH;
                end
                else if (sts.used_zero)
                begin
                    cmd.miss   = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.match)
                begin
                    if (sts.is_remove)
                    begin
                        state_next = S_SHIFT_RD;
                    end
                    else
                    begin
                        cmd.hit    = 1'b1;
                        state_next = S_FINISH;
                    end
                end
                else if (sts.more)
                begin
                    cmd.scan_next = 1'b1;
                end
                else
                begin
                    cmd.miss   = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_SHIFT_RD:
            begin
                if (sts.more)
                begin
                    cmd.shift_rd = 1'b1;
                    state_next   = S_SHIFT_WR;
                end
                else
                begin
                    cmd.clear  = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.shift_wr = 1'b1;
                state_next   = S_SHIFT_RD;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    // one request in flight: an accepted request blocks the next cycle
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted while another is in flight");
`endif

endmodule

[hdl/vipt_datapath.sv]
// Datapath: request registers, entry memory, generation and count, result and output registers.
module vipt_datapath #(
    parameter int MAX_ENTRIES = vipt_pkg::MAX_ENTRIES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  vipt_pkg::vipt_cmd_t             cmd,
    output vipt_pkg::vipt_sts_t             sts,
    input  logic [vipt_pkg::REQ_W-1:0]      req_type,
    input  logic [vipt_pkg::ID_W-1:0]       iface_id,
    input  logic [vipt_pkg::PROF_W-1:0]     profile_code,
    input  logic [vipt_pkg::IDENT_W-1:0]    identity_word,
    input  logic [vipt_pkg::LEN_W-1:0]      identity_len,
    input  logic [vipt_pkg::GEN_W-1:0]      expected_gen,
    input  logic                            rsp_ready,
    output logic                            rsp_valid,
    output logic [vipt_pkg::STATUS_W-1:0]   status,
    output logic [vipt_pkg::GEN_W-1:0]      new_gen,
    output logic [vipt_pkg::PROF_W-1:0]     lookup_profile
);
    import vipt_pkg::*;

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_ENTRIES);

    // latched request
    logic [REQ_W-1:0]   type_reg;
    logic [ID_W-1:0]    id_reg;
    logic [PROF_W-1:0]  prof_reg;
    logic [IDENT_W-1:0] ident_reg;
    logic               ident_ok_reg;
    logic [GEN_W-1:0]   exp_gen_reg;

    // entry memory
    logic [ID_W-1:0]    mem_iface    [MAX_ENTRIES];
    logic [PROF_W-1:0]  mem_profile  [MAX_ENTRIES];
    logic [IDENT_W-1:0] mem_identity [MAX_ENTRIES];
    logic [GEN_W-1:0]   mem_gen      [MAX_ENTRIES];

    logic [ID_W-1:0]    rd_iface_reg;
    logic [PROF_W-1:0]  rd_prof_reg;
    logic [IDENT_W-1:0] rd_ident_reg;
    logic [GEN_W-1:0]   rd_gen_reg;

    logic [IW-1:0]      scan_idx_reg;
    logic [CW-1:0]      used_reg;
    logic [GEN_W-1:0]   gen_reg;

    logic [STATUS_W-1:0] res_status_reg;
    logic [GEN_W-1:0]    res_gen_reg;
    logic [PROF_W-1:0]   res_prof_reg;

    logic                rsp_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [GEN_W-1:0]    out_gen_reg;
    logic [PROF_W-1:0]   out_prof_reg;

    logic [IDENT_W-1:0] ident_masked;
    logic               len_ok;
    logic               pre_fail;
    logic [STATUS_W-1:0] pre_status;
    logic [GEN_W-1:0]   gen_inc;
    logic [CW-1:0]      idx_inc;
    logic [CW-1:0]      used_dec;
    logic               full;
    logic               do_append;
    logic               gen_bump;
    logic               rd_en;
    logic [IW-1:0]      rd_addr;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    logic [ID_W-1:0]    wr_iface;
    logic [PROF_W-1:0]  wr_prof;
    logic [IDENT_W-1:0] wr_ident;
    logic [GEN_W-1:0]   wr_gen;

    // keep only the identity bytes below identity_len
    always_comb
    begin
        for (int i = 0; i < IDENT_W / 8; i++)
        begin
            ident_masked[8*i +: 8] = (LEN_W'(i) < identity_len) ? identity_word[8*i +: 8]
                                                                 : 8'd0;
        end
        len_ok = (identity_len != '0) && (identity_len <= LEN_W'(IDENTITY_BYTES));
    end

    always_comb
    begin
        pre_fail   = 1'b0;
        pre_status = ST_OK;
        unique case (type_reg)
            REQ_SET:
            begin
                pre_fail = 1'b1;
                if (id_reg == '0)
                    pre_status = ST_INVALID;
                else if (prof_reg > PROF_TRUSTED || !ident_ok_reg)
                    pre_status = ST_MALFORMED;
                else if (exp_gen_reg != gen_reg)
                    pre_status = ST_NOT_FOUND;
                else if (gen_reg == GEN_MAX)
                    pre_status = ST_EXHAUSTED;
                else
                    pre_fail = 1'b0;
            end
            REQ_REMOVE:
            begin
                pre_fail = 1'b1;
                if (id_reg == '0)
                    pre_status = ST_INVALID;
                else if (exp_gen_reg != gen_reg)
                    pre_status = ST_NOT_FOUND;
                else if (gen_reg == GEN_MAX)
                    pre_status = ST_EXHAUSTED;
                else
                    pre_fail = 1'b0;
            end
            REQ_LOOKUP:
            begin
                // a zero id answers public without a scan
                pre_fail = (id_reg == '0);
            end
            default:
            begin
                pre_fail   = 1'b1;
                pre_status = ST_INVALID;
            end
        endcase
    end

    assign gen_inc   = gen_reg + 1'b1;
    assign idx_inc   = CW'(scan_idx_reg) + 1'b1;
    assign used_dec  = used_reg - 1'b1;
    assign full      = (used_reg >= MAX_COUNT);
    assign do_append = cmd.miss && (type_reg == REQ_SET) && !full;
    assign gen_bump  = (cmd.hit && (type_reg == REQ_SET)) || do_append || cmd.clear;

    assign rd_en   = cmd.scan_start || cmd.scan_next || cmd.shift_rd;
    assign rd_addr = cmd.scan_start ? '0 : idx_inc[IW-1:0];

    always_comb
    begin
        wr_en    = 1'b0;
        wr_addr  = scan_idx_reg;
        wr_iface = id_reg;
        wr_prof  = prof_reg;
        wr_ident = ident_reg;
        wr_gen   = gen_inc;
        if (cmd.shift_wr)
        begin
            wr_en    = 1'b1;
            wr_iface = rd_iface_reg;
            wr_prof  = rd_prof_reg;
            wr_ident = rd_ident_reg;
            wr_gen   = rd_gen_reg;
        end
        else if (cmd.clear)
        begin
            wr_en    = 1'b1;
            wr_addr  = used_dec[IW-1:0];
            wr_iface = '0;
            wr_prof  = '0;
            wr_ident = '0;
            wr_gen   = '0;
        end
        else if (cmd.hit && (type_reg == REQ_SET))
        begin
            wr_en = 1'b1;
        end
        else if (do_append)
        begin
            wr_en   = 1'b1;
            wr_addr = used_reg[IW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_iface[wr_addr]    <= wr_iface;
            mem_profile[wr_addr]  <= wr_prof;
            mem_identity[wr_addr] <= wr_ident;
            mem_gen[wr_addr]      <= wr_gen;
        end
        if (rd_en)
        begin
            rd_iface_reg <= mem_iface[rd_addr];
            rd_prof_reg  <= mem_profile[rd_addr];
            rd_ident_reg <= mem_identity[rd_addr];
            rd_gen_reg   <= mem_gen[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            type_reg     <= req_type;
            id_reg       <= iface_id;
            prof_reg     <= profile_code;
            ident_reg    <= ident_masked;
            ident_ok_reg <= len_ok && (ident_masked != '0);
            exp_gen_reg  <= expected_gen;
        end
        if (cmd.scan_start)
            scan_idx_reg <= '0;
        else if (cmd.scan_next || cmd.shift_wr)
            scan_idx_reg <= idx_inc[IW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pre_done)
        begin
            res_status_reg <= pre_status;
            res_gen_reg    <= '0;
            res_prof_reg   <= PROF_PUBLIC;
        end
        else if (cmd.hit)
        begin
            res_status_reg <= ST_OK;
            res_gen_reg    <= (type_reg == REQ_SET) ? gen_inc : '0;
            res_prof_reg   <= (type_reg == REQ_LOOKUP) ? rd_prof_reg : PROF_PUBLIC;
        end
        else if (cmd.miss)
        begin
            res_prof_reg <= PROF_PUBLIC;
            res_gen_reg  <= do_append ? gen_inc : '0;
            if (type_reg == REQ_REMOVE)
                res_status_reg <= ST_NOT_FOUND;
            else if (type_reg == REQ_SET && full)
                res_status_reg <= ST_FULL;
            else
                res_status_reg <= ST_OK;
        end
        else if (cmd.clear)
        begin
            res_status_reg <= ST_OK;
            res_gen_reg    <= gen_inc;
            res_prof_reg   <= PROF_PUBLIC;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_gen_reg    <= res_gen_reg;
            out_prof_reg   <= res_prof_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            gen_reg       <= GEN_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (do_append)
                used_reg <= used_reg + 1'b1;
            else if (cmd.clear)
                used_reg <= used_dec;
            if (gen_bump)
                gen_reg <= gen_inc;
            if (cmd.load_out)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        sts.pre_fail  = pre_fail;
        sts.is_remove = (type_reg == REQ_REMOVE);
        sts.used_zero = (used_reg == '0);
        sts.match     = (rd_iface_reg == id_reg);
        sts.more      = (idx_inc < used_reg);
        sts.out_free  = !rsp_valid_reg || rsp_ready;
    end

    assign rsp_valid      = rsp_valid_reg;
    assign status         = out_status_reg;
    assign new_gen        = out_gen_reg;
    assign lookup_profile = out_prof_reg;

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= MAX_COUNT)
        else $error("entry count beyond table size");

    a_gen_step: assert property (@(posedge clk) disable iff (!rst_n)
        (gen_reg != $past(gen_reg)) |-> (gen_reg == $past(gen_reg) + 1'b1))
        else $error("generation moved by other than one");

    a_count_needs_gen: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg != $past(used_reg)) |-> (gen_reg != $past(gen_reg)))
        else $error("entry count changed without a generation bump");

    a_fail_zero_gen: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && out_status_reg != ST_OK) |-> (out_gen_reg == '0))
        else $error("failed request reports a generation");
`endif

endmodule

[hdl/versioned_interface_profile_table.sv]
// Versioned interface profile table.
// Requests arrive on req (valid/ready): set, remove or look up an interface id.
// Each request yields exactly one response on rsp (valid/ready) carrying status,
// the new generation after a successful set or remove, and the looked-up profile.
// One request is worked at a time. Entries live in a single-port memory that is
// scanned one entry per cycle; a remove then moves each later entry down with a
// read and then a write. A rejected request or a zero-id lookup finishes after
// the precheck, and any request on an empty table finishes with no scan; others
// scan until they find the id or pass the last entry, and a remove at slot k of
// u entries then shifts the u - 1 - k entries above it down one slot each.
// The next request is taken the cycle after the result moves to the output
// register, so a stalled receiver holds one finished response while the block
// works the next request; a second result then waits until rsp is taken.
// Reset empties the table (entry count zero) and sets the generation to one;
// no clearing pass is needed since only slots below the count are ever read.
module versioned_interface_profile_table #(
    parameter int MAX_ENTRIES = vipt_pkg::MAX_ENTRIES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    vipt_req_if.sink   req,
    vipt_rsp_if.source rsp
);
    import vipt_pkg::*;

    vipt_cmd_t cmd;
    vipt_sts_t sts;

    vipt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    vipt_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .req_type       (req.req_type),
        .iface_id       (req.iface_id),
        .profile_code   (req.profile_code),
        .identity_word  (req.identity_word),
        .identity_len   (req.identity_len),
        .expected_gen   (req.expected_gen),
        .rsp_ready      (rsp.ready),
        .rsp_valid      (rsp.valid),
        .status         (rsp.status),
        .new_gen        (rsp.new_gen),
        .lookup_profile (rsp.lookup_profile)
    );

endmodule

[tb/sv/tb_versioned_interface_profile_table.sv]
// Testbench for the versioned interface profile table: directed rows, then random requests.
module tb_versioned_interface_profile_table;
    import vipt_pkg::*;

    localparam logic [REQ_W-1:0]  REQ_UNUSED     = 2'd3;
    localparam logic [PROF_W-1:0] PROF_PRIVATE   = 2'd1;
    localparam logic [PROF_W-1:0] PROF_MALFORMED = 2'd3;
    localparam int TABLE_DEPTH   = MAX_ENTRIES_DEF;
    localparam int RANDOM_ITEMS  = 500;
    localparam int ID_POOL       = 24;
    localparam int LONG_HOLD     = 400;
    localparam int DRAIN_CYCLES  = 60;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int MAX_PRINTED   = 60;
    localparam int ROW_COUNT     = 25;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [ID_W-1:0]    iface_id;
        logic [PROF_W-1:0]  profile_code;
        logic [IDENT_W-1:0] identity_word;
        logic [LEN_W-1:0]   identity_len;
        logic [GEN_W-1:0]   expected_gen;
    } table_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [GEN_W-1:0]    new_gen;
        logic [PROF_W-1:0]   lookup_profile;
    } table_rsp_t;

    typedef struct packed {
        table_req_t rq;
        logic       typed;
        table_rsp_t answer;
    } stim_row_t;

    logic clk;
    logic rst_n;

    vipt_req_if req_ch ();
    vipt_rsp_if rsp_ch ();

    versioned_interface_profile_table uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // mirror of the table contents that decide the answers
    logic [ID_W-1:0]   tbl_id   [TABLE_DEPTH];
    logic [PROF_W-1:0] tbl_prof [TABLE_DEPTH];
    int                tbl_used;
    logic [GEN_W-1:0]  tbl_gen;

    table_rsp_t pending_answers[$];
    stim_row_t  rows[ROW_COUNT];
    int         errors;
    int         rsp_count;
    int         cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (errors < MAX_PRINTED)
            $display("mismatch at response %0d: %s got %0h expected %0h",
                     rsp_count, what, got, want);
        errors++;
    endtask

    function automatic void clear_table();
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            tbl_id[i]   = '0;
            tbl_prof[i] = PROF_PUBLIC;
        end
        tbl_used = 0;
        tbl_gen  = GEN_RESET;
    endfunction

    function automatic int find_entry(input logic [ID_W-1:0] id);
        for (int i = 0; i < tbl_used; i++)
            if (tbl_id[i] == id)
                return i;
        return -1;
    endfunction

    // work one request against the mirror and return its answer
    function automatic table_rsp_t table_answer(input table_req_t r);
        table_rsp_t       o;
        logic [IDENT_W-1:0] mask;
        logic             ident_ok;
        int               slot;
        o    = '0;
        mask = '0;
        slot = find_entry(r.iface_id);
        o.status = ST_OK;
        case (r.req_type)
            REQ_SET:
            begin
                for (int b = 0; b < IDENTITY_BYTES; b++)
                    if (b < r.identity_len)
                        mask[8*b +: 8] = 8'hFF;
                ident_ok = (r.identity_len >= 1) && (r.identity_len <= IDENTITY_BYTES)
                           && ((r.identity_word & mask) != '0);
                if (r.iface_id == '0)
                    o.status = ST_INVALID;
                else if (r.profile_code == PROF_MALFORMED || !ident_ok)
                    o.status = ST_MALFORMED;
                else if (r.expected_gen != tbl_gen)
                    o.status = ST_NOT_FOUND;
                else if (tbl_gen == GEN_MAX)
                    o.status = ST_EXHAUSTED;
                else if (slot < 0 && tbl_used >= TABLE_DEPTH)
                    o.status = ST_FULL;
                else
                begin
                    if (slot < 0)
                    begin
                        slot = tbl_used;
                        tbl_used++;
                        tbl_id[slot] = r.iface_id;
                    end
                    tbl_prof[slot] = r.profile_code;
                    tbl_gen++;
                    o.new_gen = tbl_gen;
                end
            end
            REQ_REMOVE:
            begin
                if (r.iface_id == '0)
                    o.status = ST_INVALID;
                else if (r.expected_gen != tbl_gen)
                    o.status = ST_NOT_FOUND;
                else if (tbl_gen == GEN_MAX)
                    o.status = ST_EXHAUSTED;
                else if (slot < 0)
                    o.status = ST_NOT_FOUND;
                else
                begin
                    // close the gap and drop the last slot
                    for (int i = slot; i + 1 < tbl_used; i++)
                    begin
                        tbl_id[i]   = tbl_id[i+1];
                        tbl_prof[i] = tbl_prof[i+1];
                    end
                    tbl_used--;
                    tbl_id[tbl_used]   = '0;
                    tbl_prof[tbl_used] = PROF_PUBLIC;
                    tbl_gen++;
                    o.new_gen = tbl_gen;
                end
            end
            REQ_LOOKUP:
            begin
                if (r.iface_id != '0 && slot >= 0)
                    o.lookup_profile = tbl_prof[slot];
            end
            default:
                o.status = ST_INVALID;
        endcase
        return o;
    endfunction

    function automatic stim_row_t row(input logic [REQ_W-1:0] kind,
                                      input logic [ID_W-1:0] id,
                                      input logic [PROF_W-1:0] prof,
                                      input logic [IDENT_W-1:0] word,
                                      input logic [LEN_W-1:0] len,
                                      input logic [GEN_W-1:0] egen,
                                      input logic typed,
                                      input logic [STATUS_W-1:0] st,
                                      input logic [GEN_W-1:0] ngen,
                                      input logic [PROF_W-1:0] lp);
        stim_row_t s;
        s.rq     = '{kind, id, prof, word, len, egen};
        s.typed  = typed;
        s.answer = '{st, ngen, lp};
        return s;
    endfunction

    // quiet stretches: every fourth block of 40 requests runs without gaps
    function automatic int draw_gap(input int n);
        if ((n / 40) % 4 == 3)
            return 0;
        return $urandom_range(0, 8);
    endfunction

    function automatic table_req_t random_request();
        table_req_t r;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            // noise: every field drawn over its full width
            r.req_type      = REQ_W'($urandom_range(0, 3));
            r.iface_id      = $urandom;
            r.profile_code  = PROF_W'($urandom_range(0, 3));
            r.identity_word = {$urandom, $urandom};
            r.identity_len  = LEN_W'($urandom_range(0, 255));
            r.expected_gen  = ($urandom_range(0, 1) == 0) ? {$urandom, $urandom} : tbl_gen;
            if ($urandom_range(0, 3) == 0)
                r.iface_id = '0;
            return r;
        end
        pick = $urandom_range(0, 99);
        if (pick < 45)
            r.req_type = REQ_SET;
        else if (pick < 65)
            r.req_type = REQ_REMOVE;
        else if (pick < 96)
            r.req_type = REQ_LOOKUP;
        else
            r.req_type = REQ_UNUSED;
        r.iface_id      = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, ID_POOL);
        r.profile_code  = PROF_W'($urandom_range(0, 2));
        r.identity_word = {$urandom, $urandom};
        r.identity_len  = LEN_W'($urandom_range(1, IDENTITY_BYTES));
        pick = $urandom_range(0, 19);
        if (pick == 0)
            r.expected_gen = tbl_gen - 1;
        else if (pick == 1)
            r.expected_gen = tbl_gen + 1;
        else
            r.expected_gen = tbl_gen;
        return r;
    endfunction

    // offer one request, hold it until taken, then record its answer
    task automatic push_request(input table_req_t r, input logic typed,
                                input table_rsp_t typed_answer, input int n);
        int         gap;
        table_rsp_t predicted;
        gap = draw_gap(n);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= r.req_type;
        req_ch.iface_id      <= r.iface_id;
        req_ch.profile_code  <= r.profile_code;
        req_ch.identity_word <= r.identity_word;
        req_ch.identity_len  <= r.identity_len;
        req_ch.expected_gen  <= r.expected_gen;
        do @(posedge clk); while (!req_ch.ready);
        predicted = table_answer(r);
        pending_answers.push_back(typed ? typed_answer : predicted);
    endtask

    // receiver: random stalls plus two long hold-offs that back up the block
    initial
    begin
        int stall;
        int taken;
        taken = 0;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = draw_gap(taken);
            if (taken == 60 || taken == 350)
                stall = LONG_HOLD;
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
            taken++;
        end
    end

    always @(posedge clk)
    begin
        table_rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_answers.size() == 0)
                report_mismatch("response with nothing outstanding, status",
                                64'(rsp_ch.status), '0);
            else
            begin
                want = pending_answers.pop_front();
                if (rsp_ch.status !== want.status)
                    report_mismatch("status", 64'(rsp_ch.status), 64'(want.status));
                if (rsp_ch.new_gen !== want.new_gen)
                    report_mismatch("new_gen", rsp_ch.new_gen, want.new_gen);
                if (rsp_ch.lookup_profile !== want.lookup_profile)
                    report_mismatch("lookup_profile", 64'(rsp_ch.lookup_profile),
                                    64'(want.lookup_profile));
            end
            rsp_count++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        errors      = 0;
        rsp_count   = 0;
        cycle_count = 0;
        clear_table();
        rst_n                <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.req_type      <= REQ_LOOKUP;
        req_ch.iface_id      <= '0;
        req_ch.profile_code  <= PROF_PUBLIC;
        req_ch.identity_word <= '0;
        req_ch.identity_len  <= '0;
        req_ch.expected_gen  <= '0;

        // lookups and argument errors on the empty table
        rows[0]  = row(REQ_LOOKUP, 32'd0, PROF_PUBLIC, 64'd0, 8'd0, 64'd0,
                       1'b1, ST_OK, 64'd0, PROF_PUBLIC);
        rows[1]  = row(REQ_LOOKUP, 32'd5, PROF_PUBLIC, 64'd0, 8'd0, 64'd0,
                       1'b1, ST_OK, 64'd0, PROF_PUBLIC);
        rows[2]  = row(REQ_UNUSED, 32'd5, PROF_PRIVATE, 64'd1, 8'd1, GEN_RESET,
                       1'b1, ST_INVALID, 64'd0, PROF_PUBLIC);
        rows[3]  = row(REQ_SET, 32'd0, PROF_PRIVATE, 64'd1, 8'd1, GEN_RESET,
                       1'b1, ST_INVALID, 64'd0, PROF_PUBLIC);
        rows[4]  = row(REQ_SET, 32'd1, PROF_MALFORMED, 64'd1, 8'd1, GEN_RESET,
                       1'b1, ST_MALFORMED, 64'd0, PROF_PUBLIC);
        rows[5]  = row(REQ_SET, 32'd1, PROF_PRIVATE, 64'hFF, 8'd0, GEN_RESET,
                       1'b1, ST_MALFORMED, 64'd0, PROF_PUBLIC);
        rows[6]  = row(REQ_SET, 32'd1, PROF_PRIVATE, 64'hFF, 8'd9, GEN_RESET,
                       1'b1, ST_MALFORMED, 64'd0, PROF_PUBLIC);
        rows[7]  = row(REQ_SET, 32'd1, PROF_PRIVATE, 64'hFF, 8'd255, GEN_RESET,
                       1'b1, ST_MALFORMED, 64'd0, PROF_PUBLIC);
        // identity bytes below the length all zero
        rows[8]  = row(REQ_SET, 32'd1, PROF_PRIVATE, 64'hFFFF_FFFF_FFFF_0000, 8'd2,
                       GEN_RESET, 1'b1, ST_MALFORMED, 64'd0, PROF_PUBLIC);
        rows[9]  = row(REQ_SET, 32'd1, PROF_PRIVATE, 64'd1, 8'd1, 64'd0,
                       1'b1, ST_NOT_FOUND, 64'd0, PROF_PUBLIC);
        rows[10] = row(REQ_SET, 32'd1, PROF_PRIVATE, 64'd1, 8'd1, GEN_MAX,
                       1'b1, ST_NOT_FOUND, 64'd0, PROF_PUBLIC);
        // appends, lookups and an update in place
        rows[11] = row(REQ_SET, 32'hFFFF_FFFF, PROF_TRUSTED, {64{1'b1}}, 8'd8, 64'd1,
                       1'b1, ST_OK, 64'd2, PROF_PUBLIC);
        rows[12] = row(REQ_SET, 32'd1, PROF_PRIVATE, 64'h100, 8'd2, 64'd2,
                       1'b1, ST_OK, 64'd3, PROF_PUBLIC);
        rows[13] = row(REQ_LOOKUP, 32'hFFFF_FFFF, PROF_PUBLIC, 64'd0, 8'd0, 64'd0,
                       1'b1, ST_OK, 64'd0, PROF_TRUSTED);
        rows[14] = row(REQ_SET, 32'hFFFF_FFFF, PROF_PUBLIC, 64'h8000_0000_0000_0000, 8'd8,
                       64'd3, 1'b1, ST_OK, 64'd4, PROF_PUBLIC);
        rows[15] = row(REQ_SET, 32'd2, PROF_TRUSTED, 64'hAA, 8'd1, 64'd4,
                       1'b1, ST_OK, 64'd5, PROF_PUBLIC);
        rows[16] = row(REQ_LOOKUP, 32'hFFFF_FFFF, PROF_PUBLIC, 64'd0, 8'd0, 64'd0,
                       1'b0, ST_OK, 64'd0, PROF_PUBLIC);
        // remove: zero id, stale generation, absent id, first and last slot
        rows[17] = row(REQ_REMOVE, 32'd0, PROF_PUBLIC, 64'd0, 8'd0, 64'd5,
                       1'b1, ST_INVALID, 64'd0, PROF_PUBLIC);
        rows[18] = row(REQ_REMOVE, 32'd1, PROF_PUBLIC, 64'd0, 8'd0, 64'd4,
                       1'b1, ST_NOT_FOUND, 64'd0, PROF_PUBLIC);
        rows[19] = row(REQ_REMOVE, 32'd7, PROF_PUBLIC, 64'd0, 8'd0, 64'd5,
                       1'b1, ST_NOT_FOUND, 64'd0, PROF_PUBLIC);
        rows[20] = row(REQ_REMOVE, 32'hFFFF_FFFF, PROF_PUBLIC, 64'd0, 8'd0, 64'd5,
                       1'b1, ST_OK, 64'd6, PROF_PUBLIC);
        rows[21] = row(REQ_LOOKUP, 32'd2, PROF_PUBLIC, 64'd0, 8'd0, 64'd0,
                       1'b0, ST_OK, 64'd0, PROF_PUBLIC);
        rows[22] = row(REQ_REMOVE, 32'd2, PROF_PUBLIC, 64'd0, 8'd0, 64'd6,
                       1'b1, ST_OK, 64'd7, PROF_PUBLIC);
        rows[23] = row(REQ_LOOKUP, 32'd1, PROF_PUBLIC, 64'd0, 8'd0, 64'd0,
                       1'b0, ST_OK, 64'd0, PROF_PUBLIC);
        rows[24] = row(REQ_SET, 32'd1, PROF_PUBLIC, 64'h0100_0000_0000_0000, 8'd8, 64'd7,
                       1'b0, ST_OK, 64'd0, PROF_PUBLIC);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < ROW_COUNT; i++)
            push_request(rows[i].rq, rows[i].typed, rows[i].answer, i);
        for (int i = 0; i < RANDOM_ITEMS; i++)
            push_request(random_request(), 1'b0, '0, ROW_COUNT + i);
        req_ch.valid <= 1'b0;

        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[filelist.f]
hdl/vipt_pkg.sv
hdl/vipt_req_if.sv
hdl/vipt_rsp_if.sv
hdl/vipt_ctrl.sv
hdl/vipt_datapath.sv
hdl/versioned_interface_profile_table.sv
tb/sv/tb_versioned_interface_profile_table.sv
